// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/gvc_pkg.sv =====
// ----------------------------------------------------------------------------
// gvc_pkg
// shared constants, microcode word and status types for the colouring block
// ----------------------------------------------------------------------------
package gvc_pkg;

  localparam int NUM_VERTICES_DEF = 32;
  localparam int MASK_W           = 32;
  localparam int VERTEX_W         = 5;
  localparam int COLOUR_W         = 6;
  localparam logic [COLOUR_W-1:0] UNCOLOURED = 6'd63;
  localparam int NUM_COLOURS      = MASK_W + 1;
  localparam int CHUNK_W          = 8;
  localparam int CHUNK_IDX_W      = 3;
  localparam int NUM_CHUNKS       = (NUM_COLOURS + CHUNK_W - 1) / CHUNK_W;
  localparam int FREE_W           = NUM_CHUNKS * CHUNK_W;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_SCAN   = 3'd1;
  localparam step_t STEP_DRAIN  = 3'd2;
  localparam step_t STEP_PREP   = 3'd3;
  localparam step_t STEP_SEARCH = 3'd4;
  localparam step_t STEP_DONE   = 3'd5;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_SCAN,
    OP_DRAIN,
    OP_PREP,
    OP_SEARCH,
    OP_DONE
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_IN,
    COND_MORE,
    COND_NOT_FOUND,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  last;
  } ctrl_t;

  typedef struct packed {
    logic in_accept;
    logic scan_more;
    logic not_found;
    logic out_busy;
  } status_t;

  // index of the lowest set bit, zero when none
  function automatic logic [CHUNK_IDX_W-1:0] first_set(input logic [CHUNK_W-1:0] bits);
    logic [CHUNK_IDX_W-1:0] pos;
    pos = '0;
    for (int k = CHUNK_W - 1; k >= 0; k--) begin
      if (bits[k]) begin
        pos = CHUNK_IDX_W'(k);
      end
    end
    return pos;
  endfunction

endpackage

// ===== design/greedy_vertex_colouring.sv =====
// ----------------------------------------------------------------------------
// greedy_vertex_colouring
// Each transaction names a vertex and its adjacency row; the block returns
// the smallest colour from 0 to the vertex degree that no coloured neighbour
// holds, and records it in its colour table (all uncoloured after reset).
// One vertex is processed at a time: the table is scanned one entry a cycle
// through its single read port while the degree is counted, then drain and
// prep steps follow, the free colour is searched eight colours a step, and
// the result is registered once the previous output is no longer stalled.
// The next vertex is taken once its predecessor's result is in the output
// register, even while that result still waits to be taken.
// ----------------------------------------------------------------------------
module greedy_vertex_colouring
  import gvc_pkg::*;
#(
  parameter int NUM_VERTICES = NUM_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [VERTEX_W-1:0] vertex,
  input  logic [MASK_W-1:0]   neighbour_mask,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VERTEX_W-1:0] vertex_out,
  output logic [COLOUR_W-1:0] assigned_colour
);

  localparam int LIVE = (NUM_VERTICES < MASK_W) ? NUM_VERTICES : MASK_W;
  localparam int IDXW = $clog2(LIVE);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(LIVE - 1);

  ctrl_t   ctrl;
  status_t status;

  logic                in_accept;
  logic                out_busy;
  logic [VERTEX_W-1:0] cur_vertex;
  logic [LIVE-1:0]     row;
  logic [IDXW-1:0]     idx;
  logic [COLOUR_W-1:0] degree;
  logic [FREE_W-1:0]   taken;
  logic [FREE_W-1:0]   free_flat;
  logic [NUM_CHUNKS-1:0][CHUNK_W-1:0] free;
  logic [CHUNK_IDX_W-1:0] chunk;
  logic [CHUNK_W-1:0]  chunk_bits;
  logic [COLOUR_W-1:0] colour;
  logic                rd_hit;
  logic                rd_valid;
  logic [COLOUR_W-1:0] rd_data;
  logic [COLOUR_W-1:0] rd_colour;
  logic                table_wr;

  logic [COLOUR_W-1:0] colour_mem [LIVE];
  logic [LIVE-1:0]     entry_valid;

  gvc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  assign in_ready   = (ctrl.op == OP_IDLE);
  assign in_accept  = in_valid && in_ready;
  assign out_busy   = out_valid && !out_ready;
  assign chunk_bits = free[chunk];
  assign rd_colour  = rd_valid ? rd_data : UNCOLOURED;
  assign table_wr   = (ctrl.op == OP_DONE) && !out_busy
                      && ({1'b0, cur_vertex} < (VERTEX_W + 1)'(LIVE));

  assign status.in_accept = in_accept;
  assign status.scan_more = (idx != LAST_IDX);
  assign status.not_found = (chunk_bits == '0);
  assign status.out_busy  = out_busy;

  // free colours below the degree, plus the degree itself as the fallback
  always_comb begin
    for (int k = 0; k < FREE_W; k++) begin
      if (COLOUR_W'(k) < degree) begin
        free_flat[k] = !taken[k];
      end else begin
        free_flat[k] = (COLOUR_W'(k) == degree);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_IDLE: begin
        if (in_accept) begin
          cur_vertex <= vertex;
          row        <= neighbour_mask[LIVE-1:0];
          idx        <= '0;
          degree     <= '0;
          taken      <= '0;
          rd_hit     <= 1'b0;
        end
      end
      OP_SCAN: begin
        rd_hit   <= row[idx];
        rd_data  <= colour_mem[idx];
        rd_valid <= entry_valid[idx];
        degree   <= degree + COLOUR_W'(row[idx]);
        idx      <= idx + IDXW'(1);
        if (rd_hit && rd_colour <= COLOUR_W'(NUM_COLOURS - 1)) begin
          taken[rd_colour] <= 1'b1;
        end
      end
      OP_DRAIN: begin
        if (rd_hit && rd_colour <= COLOUR_W'(NUM_COLOURS - 1)) begin
          taken[rd_colour] <= 1'b1;
        end
      end
      OP_PREP: begin
        free  <= free_flat;
        chunk <= '0;
      end
      OP_SEARCH: begin
        if (chunk_bits != '0) begin
          colour <= {chunk, first_set(chunk_bits)};
        end else begin
          chunk <= chunk + CHUNK_IDX_W'(1);
        end
      end
      OP_DONE: begin
        if (!out_busy) begin
          vertex_out      <= cur_vertex;
          assigned_colour <= colour;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (table_wr) begin
      colour_mem[cur_vertex[IDXW-1:0]] <= colour;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (table_wr) begin
        entry_valid[cur_vertex[IDXW-1:0]] <= 1'b1;
      end
      if ((ctrl.op == OP_DONE) && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEXT(a_one_at_a_time, in_accept, !in_ready)
  `ASSERT_IMPL(a_colour_in_range, $rose(out_valid), assigned_colour <= COLOUR_W'(MASK_W))
  `ASSERT_IMPL(a_colour_within_degree, table_wr, colour <= degree)
  `ASSERT_IMPL(a_search_ends, ctrl.op == OP_SEARCH, chunk < CHUNK_IDX_W'(NUM_CHUNKS))

endmodule

// ===== design/gvc_seq.sv =====
// ----------------------------------------------------------------------------
// gvc_seq
// microcode sequencer: step counter, control store and conditional jumps
// ----------------------------------------------------------------------------
module gvc_seq
  import gvc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  step_t step;
  step_t step_next;
  logic  jump;

  always_comb begin
    case (step)
      STEP_IDLE:   ctrl = '{op: OP_IDLE,   cond: COND_NO_IN,     target: STEP_IDLE,   last: 1'b0};
      STEP_SCAN:   ctrl = '{op: OP_SCAN,   cond: COND_MORE,      target: STEP_SCAN,   last: 1'b0};
      STEP_DRAIN:  ctrl = '{op: OP_DRAIN,  cond: COND_NEVER,     target: STEP_IDLE,   last: 1'b0};
      STEP_PREP:   ctrl = '{op: OP_PREP,   cond: COND_NEVER,     target: STEP_IDLE,   last: 1'b0};
      STEP_SEARCH: ctrl = '{op: OP_SEARCH, cond: COND_NOT_FOUND, target: STEP_SEARCH, last: 1'b0};
      STEP_DONE:   ctrl = '{op: OP_DONE,   cond: COND_OUT_BUSY,  target: STEP_DONE,   last: 1'b1};
      default:     ctrl = '{op: OP_IDLE,   cond: COND_NEVER,     target: STEP_IDLE,   last: 1'b1};
    endcase
  end

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:     jump = 1'b0;
      COND_NO_IN:     jump = !status.in_accept;
      COND_MORE:      jump = status.scan_more;
      COND_NOT_FOUND: jump = status.not_found;
      COND_OUT_BUSY:  jump = status.out_busy;
      default:        jump = 1'b0;
    endcase
  end

  always_comb begin
    if (jump) begin
      step_next = ctrl.target;
    end else if (ctrl.last) begin
      step_next = STEP_IDLE;
    end else begin
      step_next = step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule
